// File: hw/rtl/rletok_pkg.sv
// Shared types, codes and helpers for the run-length token image decoder.
`default_nettype none

package rletok_pkg;

  localparam int unsigned PosW      = 25;
  localparam int unsigned IndexW    = 24;
  localparam int unsigned PixelW    = 16;
  localparam int unsigned DimW      = 13;
  localparam int unsigned RunW      = 6;
  localparam int unsigned OffW      = 5;
  localparam int unsigned OutDataW  = 48;

  localparam logic [DimW-1:0] MaxDim   = 13'd4096;
  localparam logic [PosW-1:0] PosMax   = 25'h1FF_FFFF;
  localparam logic [PosW-1:0] FrameRst = 25'h100_0000;
  localparam logic [RunW-1:0] MaxRun   = 6'd32;

  localparam logic CfgLinePitch   = 1'b0;
  localparam logic CfgImageHeight = 1'b1;

  typedef enum logic [2:0] {
    TOK_STREAM      = 3'd0,
    TOK_TRANSPARENT = 3'd1,
    TOK_REPEAT      = 3'd2,
    TOK_LINEFEED    = 3'd4
  } tok_type_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_OVERRUN  = 3'd2,
    ST_BAD_LF   = 3'd3,
    ST_PAST     = 3'd4,
    ST_UNKNOWN  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    PH_TOKEN  = 2'd0,
    PH_STREAM = 2'd1,
    PH_REPEAT = 2'd2
  } phase_e;

  typedef struct packed {
    logic              we;
    logic [IndexW-1:0] index;
    logic [PixelW-1:0] value;
    status_e           status;
    logic              done;
    logic [RunW-1:0]   count;
  } cmd_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) r = 13'd1;
    else if (v > MaxDim) r = MaxDim;
    return r;
  endfunction

  function automatic logic [PosW-1:0] sat_pos(input logic [PosW:0] s);
    logic [PosW-1:0] r;
    r = s[PosW-1:0];
    if (s > {1'b0, PosMax}) r = PosMax;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rletok_parser.sv
// Front end: token and pixel byte parser, cursor tracking and config registers.
`default_nettype none

module rletok_parser (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [12:0]         cfg_data,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [7:0]          s_tdata,
  input  wire logic                s_tuser,
  input  wire logic                s_tlast,
  input  wire logic                q_full,
  output logic                     push,
  output rletok_pkg::cmd_t         cmd
);
  import rletok_pkg::*;

  logic [DimW-1:0] pitch, pitch_next;
  logic [DimW-1:0] height, height_next;
  logic [PosW-1:0] frame_end;
  logic [2*DimW-1:0] frame_prod;

  phase_e          phase, phase_next;
  logic            half, half_next;
  logic [7:0]      hold, hold_next;
  logic [RunW-1:0] run, run_next;
  logic [PosW-1:0] cursor, cursor_next;
  logic [PosW-1:0] nls, nls_next;
  logic            halted, halted_next;

  logic            acc;
  phase_e          e_phase;
  logic            e_half;
  logic [7:0]      e_hold;
  logic [RunW-1:0] e_run;
  logic [PosW-1:0] e_cursor;
  logic [PosW-1:0] e_nls;
  logic            e_halted;

  tok_type_e       ttype;
  logic [RunW-1:0] len;
  logic [PosW:0]   run_end;
  status_e         tok_status;
  logic [RunW-1:0] run_dec;
  logic [RunW-1:0] rep_n;

  assign s_tready = !q_full;
  assign acc      = s_tvalid && s_tready;

  assign e_phase  = s_tuser ? PH_TOKEN : phase;
  assign e_half   = s_tuser ? 1'b0 : half;
  assign e_hold   = s_tuser ? 8'd0 : hold;
  assign e_run    = s_tuser ? '0 : run;
  assign e_cursor = s_tuser ? '0 : cursor;
  assign e_nls    = s_tuser ? PosW'(pitch) : nls;
  assign e_halted = s_tuser ? 1'b0 : halted;

  assign ttype   = tok_type_e'(s_tdata[7:5]);
  assign len     = {1'b0, s_tdata[4:0]} + 6'd1;
  assign run_end = {1'b0, e_cursor} + (PosW+1)'(len);
  assign run_dec = (e_run == '0) ? '0 : e_run - 6'd1;
  assign rep_n   = (e_run > MaxRun) ? MaxRun : e_run;

  // config registers; frame size follows each write
  always_comb begin
    pitch_next  = pitch;
    height_next = height;
    if (cfg_we) begin
      unique case (cfg_index)
        CfgLinePitch:   pitch_next  = clamp_dim(cfg_data);
        CfgImageHeight: height_next = clamp_dim(cfg_data);
        default: ;
      endcase
    end
  end

  assign frame_prod = pitch_next * height_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch     <= MaxDim;
      height    <= MaxDim;
      frame_end <= FrameRst;
    end else begin
      pitch     <= pitch_next;
      height    <= height_next;
      frame_end <= frame_prod[PosW-1:0];
    end
  end

  always_comb begin
    unique case (ttype)
      TOK_LINEFEED: begin
        if (s_tdata[4:0] != 5'd0) tok_status = ST_BAD_LF;
        else if (e_cursor > e_nls) tok_status = ST_PAST;
        else tok_status = ST_OK;
      end
      TOK_TRANSPARENT: tok_status = (e_cursor < frame_end) ? ST_OK : ST_OVERFLOW;
      TOK_STREAM, TOK_REPEAT: begin
        if (run_end > {1'b0, frame_end}) tok_status = ST_OVERFLOW;
        else if (s_tlast) tok_status = ST_OVERRUN;
        else tok_status = ST_OK;
      end
      default: tok_status = ST_UNKNOWN;
    endcase
  end

  // next state
  always_comb begin
    phase_next = phase;
    if (acc) begin
      phase_next = e_phase;
      if (!e_halted) begin
        unique case (e_phase)
          PH_TOKEN: begin
            if (tok_status == ST_OK && ttype == TOK_STREAM) phase_next = PH_STREAM;
            else if (tok_status == ST_OK && ttype == TOK_REPEAT) phase_next = PH_REPEAT;
          end
          PH_STREAM: if (e_half && run_dec == '0) phase_next = PH_TOKEN;
          PH_REPEAT: if (e_half) phase_next = PH_TOKEN;
          default:   phase_next = PH_TOKEN;
        endcase
      end
    end
  end

  // datapath and command
  always_comb begin
    cursor_next = cursor;
    nls_next    = nls;
    half_next   = half;
    hold_next   = hold;
    run_next    = run;
    halted_next = halted;
    push        = 1'b0;
    cmd         = '0;
    cmd.status  = ST_OK;
    cmd.count   = 6'd1;
    if (acc) begin
      cursor_next = e_cursor;
      nls_next    = e_nls;
      half_next   = e_half;
      hold_next   = e_hold;
      run_next    = e_run;
      halted_next = e_halted;
      if (!e_halted) begin
        push     = 1'b1;
        cmd.done = s_tlast;
        if (e_phase == PH_TOKEN) begin
          cmd.status = tok_status;
          if (tok_status != ST_OK) begin
            halted_next = 1'b1;
          end else begin
            unique case (ttype)
              TOK_LINEFEED: begin
                cursor_next = e_nls;
                nls_next    = sat_pos({1'b0, e_nls} + (PosW+1)'(pitch));
              end
              TOK_TRANSPARENT: cursor_next = sat_pos(run_end);
              TOK_STREAM, TOK_REPEAT: begin
                run_next  = len;
                half_next = 1'b0;
                hold_next = 8'd0;
              end
              default: ;
            endcase
          end
        end else if (!e_half) begin
          hold_next = s_tdata;
          half_next = 1'b1;
          if (s_tlast) begin
            cmd.status  = ST_OVERRUN;
            halted_next = 1'b1;
          end
        end else begin
          half_next = 1'b0;
          hold_next = 8'd0;
          if (e_phase == PH_STREAM) begin
            cmd.we      = 1'b1;
            cmd.index   = e_cursor[IndexW-1:0];
            cmd.value   = {s_tdata, e_hold};
            cursor_next = sat_pos({1'b0, e_cursor} + 26'd1);
            run_next    = run_dec;
            if (run_dec != '0 && s_tlast) begin
              cmd.status  = ST_OVERRUN;
              halted_next = 1'b1;
            end
          end else begin
            run_next = '0;
            if (rep_n != '0) begin
              cmd.we      = 1'b1;
              cmd.index   = e_cursor[IndexW-1:0];
              cmd.value   = {s_tdata, e_hold};
              cmd.count   = rep_n;
              cursor_next = sat_pos({1'b0, e_cursor} + (PosW+1)'(rep_n));
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_TOKEN;
      half   <= 1'b0;
      hold   <= 8'd0;
      run    <= '0;
      cursor <= '0;
      nls    <= '0;
      halted <= 1'b0;
    end else begin
      phase  <= phase_next;
      half   <= half_next;
      hold   <= hold_next;
      run    <= run_next;
      cursor <= cursor_next;
      nls    <= nls_next;
      halted <= halted_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rletok_queue.sv
// Two-entry command queue between the parser and the pixel emitter.
`default_nettype none

module rletok_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire rletok_pkg::cmd_t  cmd_in,
  input  wire logic              pop,
  output rletok_pkg::cmd_t       head,
  output logic                   empty,
  output logic                   full
);
  import rletok_pkg::*;

  cmd_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;

  assign empty = (cnt == 2'd0);
  assign full  = (cnt == 2'd2);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= cmd_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rletok_emitter.sv
// Back end: expands queued commands into output words, one per cycle while the sink is ready.
`default_nettype none

module rletok_emitter (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rletok_pkg::cmd_t  head,
  input  wire logic              empty,
  output logic                   pop,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [47:0]            m_tdata,
  output logic [1:0]             m_tuser,
  output logic                   m_tlast
);
  import rletok_pkg::*;

  logic [OffW-1:0] off;
  logic            load;
  logic            last;

  assign load = (!m_tvalid || m_tready) && !empty;
  assign last = ({1'b0, off} == head.count - 6'd1) || (head.count == '0);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      off      <= '0;
    end else begin
      if (load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (load) off <= last ? '0 : off + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {5'd0, head.status, head.value, head.index + IndexW'(off)};
      m_tlast <= last;
      m_tuser <= {head.done && last, head.we};
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rle_token_image_decoder.sv
// Top level of the run-length token image decoder.
// Takes one encoded byte per word and emits pixel write words. Token, stream
// and transparent bytes each give at most one output word; the byte that
// completes a repeat pixel gives one word per run pixel (up to 32), emitted
// one per cycle by the back-end emitter while the sink is ready. A two-entry
// command queue sits between parser and emitter, so input stalls only once
// two commands are waiting, e.g. behind an n-pixel repeat still being expanded.
// Output stays at one word per cycle when the sink is ready and commands are
// queued. Errors halt the parser until a byte with image_start set.
`default_nettype none

module rle_token_image_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte
  input  wire logic        s_tuser,   // image_start
  input  wire logic        s_tlast,   // data_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // pixel_index[23:0], pixel_value[39:24], status[42:40]
  output logic [1:0]       m_tuser,   // write_enable[0], image_done[1]
  output logic             m_tlast    // run_last
);
  import rletok_pkg::*;

  cmd_t cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;

  rletok_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .cmd      (cmd)
  );

  rletok_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .cmd_in(cmd),
    .pop   (pop),
    .head  (head),
    .empty (q_empty),
    .full  (q_full)
  );

  rletok_emitter u_emitter (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .empty   (q_empty),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

`default_nettype wire

// File: hw/rtl/rletok_checker.sv
// Port-level checks for the run-length token image decoder, bound to the top.
`default_nettype none

module rletok_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output word changed");

  a_nowrite_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[39:0] == 40'd0)
    else $error("non-write word carries index or value");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast)
    else $error("image done before end of run");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[42:40] != 3'd0 |-> m_tlast && !m_tuser[0] || m_tlast)
    else $error("error status inside a run");

endmodule

bind rle_token_image_decoder rletok_checker u_rletok_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);

`default_nettype wire

// File: bench/tb_rle_token_image_decoder.sv
// Testbench for rle_token_image_decoder: byte stream in, pixel write words out.
`timescale 1ns / 1ps

module tb_rle_token_image_decoder;
  import rletok_pkg::*;

  localparam int DrainCycles = 48;
  localparam int StallLimit  = 2000;
  localparam int HoldCycles  = 300;

  typedef struct packed {
    logic              we;
    logic [IndexW-1:0] index;
    logic [PixelW-1:0] value;
    status_e           status;
    logic              last;
    logic              done;
  } px_t;

  typedef struct packed {
    logic [7:0] b;
    logic       first;
    logic       fin;
    logic       typed;
    px_t        want;
  } row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [12:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // data_byte
  logic        s_tuser;   // image_start
  logic        s_tlast;   // data_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;   // pixel_index[23:0], pixel_value[39:24], status[42:40]
  logic [1:0]  m_tuser;   // write_enable[0], image_done[1]
  logic        m_tlast;   // run_last

  rle_token_image_decoder DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  // decoder state mirror
  logic [12:0] geo_pitch  = 13'd4096;
  logic [12:0] geo_height = 13'd4096;
  phase_e      phase      = PH_TOKEN;
  logic        half       = 1'b0;
  logic [7:0]  low_hold   = 8'd0;
  logic [5:0]  run_left   = 6'd0;
  logic [24:0] cur        = '0;
  logic [24:0] line_next  = '0;
  logic        halted     = 1'b0;

  px_t  fresh[$];
  px_t  pixel_words_due[$];
  row_t script[$];

  int errors      = 0;
  int bytes_in    = 0;
  int words_out   = 0;
  int writes_seen = 0;
  int err_words   = 0;
  int geometries  = 0;
  int burst_left  = 0;
  int hold_left   = 0;
  int pat_left    = 0;
  int pat_mode    = 0;
  bit held        = 1'b0;
  int idle_cycles = 0;

  logic [12:0] pitch_set[5]  = '{13'd0, 13'd8191, 13'd5, 13'd4097, 13'd1};
  logic [12:0] height_set[5] = '{13'd0, 13'd8191, 13'd3, 13'd1, 13'd4096};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [12:0] clip_dim(input logic [12:0] v);
    if (v == '0) return 13'd1;
    if (v > MaxDim) return MaxDim;
    return v;
  endfunction

  function automatic logic [24:0] clip_pos(input logic [25:0] s);
    if (s > {1'b0, PosMax}) return PosMax;
    return s[24:0];
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic first, input logic fin);
    px_t         r;
    logic [2:0]  kind;
    logic [5:0]  len;
    logic [5:0]  n;
    logic [5:0]  i;
    logic [25:0] frame_end;
    logic [24:0] pos;
    logic [15:0] pix;
    fresh.delete();
    if (first) begin
      cur       = '0;
      line_next = {12'd0, geo_pitch};
      halted    = 1'b0;
      phase     = PH_TOKEN;
      half      = 1'b0;
      low_hold  = '0;
      run_left  = '0;
    end
    if (halted) return;
    frame_end = 26'(geo_pitch) * 26'(geo_height);
    r = '0;
    r.status = ST_OK;
    r.last = 1'b1;
    r.done = fin;
    if (phase == PH_TOKEN) begin
      kind = b[7:5];
      len  = {1'b0, b[4:0]} + 6'd1;
      case (kind)
        TOK_LINEFEED: begin
          if (len != 6'd1) r.status = ST_BAD_LF;
          else if (cur > line_next) r.status = ST_PAST;
          else begin
            cur = line_next;
            line_next = clip_pos({1'b0, line_next} + 26'(geo_pitch));
          end
        end
        TOK_TRANSPARENT: begin
          if ({1'b0, cur} < frame_end) cur = clip_pos({1'b0, cur} + 26'(len));
          else r.status = ST_OVERFLOW;
        end
        TOK_STREAM, TOK_REPEAT: begin
          if ({1'b0, cur} + 26'(len) > frame_end) r.status = ST_OVERFLOW;
          else if (fin) r.status = ST_OVERRUN;
          else begin
            phase    = (kind == TOK_STREAM) ? PH_STREAM : PH_REPEAT;
            run_left = len;
            half     = 1'b0;
            low_hold = '0;
          end
        end
        default: r.status = ST_UNKNOWN;
      endcase
      if (r.status != ST_OK) halted = 1'b1;
      fresh.push_back(r);
      return;
    end
    if (!half) begin
      low_hold = b;
      half = 1'b1;
      if (fin) begin
        r.status = ST_OVERRUN;
        halted = 1'b1;
      end
      fresh.push_back(r);
      return;
    end
    pix      = {b, low_hold};
    half     = 1'b0;
    low_hold = '0;
    if (phase == PH_STREAM) begin
      r.we    = 1'b1;
      r.index = cur[23:0];
      r.value = pix;
      cur = clip_pos({1'b0, cur} + 26'd1);
      if (run_left > 6'd0) run_left = run_left - 6'd1;
      if (run_left == 6'd0) phase = PH_TOKEN;
      else if (fin) begin
        r.status = ST_OVERRUN;
        halted = 1'b1;
      end
      fresh.push_back(r);
      return;
    end
    n = (run_left > MaxRun) ? MaxRun : run_left;
    phase    = PH_TOKEN;
    run_left = '0;
    if (n == 6'd0) begin
      fresh.push_back(r);
      return;
    end
    for (i = 0; i < n; i++) begin
      pos     = cur + 25'(i);
      r.we    = 1'b1;
      r.index = pos[23:0];
      r.value = pix;
      r.last  = (i + 6'd1 == n);
      r.done  = r.last & fin;
      fresh.push_back(r);
    end
    cur = clip_pos({1'b0, cur} + 26'(n));
  endfunction

  task automatic add_row(input logic [7:0] b, input logic first, input logic fin,
                         input logic typed, input logic we, input logic [23:0] idx,
                         input logic [15:0] val, input status_e code, input logic last,
                         input logic done);
    row_t row;
    row.b = b;
    row.first = first;
    row.fin = fin;
    row.typed = typed;
    row.want.we = we;
    row.want.index = idx;
    row.want.value = val;
    row.want.status = code;
    row.want.last = last;
    row.want.done = done;
    script.push_back(row);
  endtask

  task automatic put_byte(input logic [7:0] b, input logic first);
    add_row(b, first, 1'b0, 1'b0, 1'b0, '0, '0, ST_OK, 1'b0, 1'b0);
  endtask

  task automatic compose_image();
    int         tokens;
    int         sel;
    int         len;
    int         base;
    logic [4:0] code;
    logic [7:0] tok;
    logic       first;
    tokens = $urandom_range(2, 7);
    base   = script.size();
    first  = ($urandom_range(0, 9) != 0);
    for (int k = 0; k < tokens; k++) begin
      len  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 4);
      code = 5'(len - 1);
      sel  = $urandom_range(0, 99);
      if (sel < 35) begin
        put_byte({TOK_STREAM, code}, first);
        repeat (2 * len) put_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (sel < 60) begin
        put_byte({TOK_REPEAT, code}, first);
        repeat (2) put_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (sel < 75) begin
        put_byte({TOK_TRANSPARENT, code}, first);
      end else if (sel < 88) begin
        put_byte({TOK_LINEFEED, 5'd0}, first);
      end else if (sel < 92) begin
        do tok = 8'($urandom_range(0, 255));
        while (tok[7:5] == TOK_STREAM || tok[7:5] == TOK_TRANSPARENT ||
               tok[7:5] == TOK_REPEAT || tok[7:5] == TOK_LINEFEED);
        put_byte(tok, first);
      end else if (sel < 96) begin
        put_byte({TOK_LINEFEED, 5'($urandom_range(1, 31))}, first);
      end else begin
        put_byte(8'($urandom_range(0, 255)), first);
      end
      first = 1'b0;
    end
    if ($urandom_range(0, 9) == 0)
      script[$urandom_range(base, script.size() - 1)].fin = 1'b1;
    else
      script[script.size() - 1].fin = 1'b1;
  endtask

  task automatic send_word(input row_t row);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= row.b;
    s_tuser  <= row.first;
    s_tlast  <= row.fin;
    do @(posedge clk); while (!s_tready);
    bytes_in++;
    decode_byte(row.b, row.first, row.fin);
    if (row.typed) pixel_words_due.push_back(row.want);
    else foreach (fresh[i]) pixel_words_due.push_back(fresh[i]);
  endtask

  task automatic run_script();
    foreach (script[i]) send_word(script[i]);
    script.delete();
  endtask

  task automatic quiesce();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pixel_words_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [12:0] pitch_raw, input logic [12:0] height_raw);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CfgLinePitch;
    cfg_data  <= pitch_raw;
    @(negedge clk);
    cfg_index <= CfgImageHeight;
    cfg_data  <= height_raw;
    @(negedge clk);
    cfg_we <= 1'b0;
    geo_pitch  = clip_dim(pitch_raw);
    geo_height = clip_dim(height_raw);
    geometries++;
  endtask

  function automatic void check_field(input string what, input logic [23:0] want,
                                      input logic [23:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  // sink: own stall pattern plus one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!held && words_out >= 80) begin
      held = 1'b1;
      hold_left = HoldCycles;
      m_tready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_mode = $urandom_range(0, 2);
        pat_left = $urandom_range(10, 60);
      end
      pat_left--;
      case (pat_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= !m_tready;
      endcase
    end
  end

  always @(posedge clk) begin
    px_t want;
    if (!rst && m_tvalid && m_tready) begin
      words_out++;
      if (m_tuser[0]) writes_seen++;
      if (m_tdata[42:40] != ST_OK) err_words++;
      if (pixel_words_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, got %h user %b last %b",
                 $time, m_tdata, m_tuser, m_tlast);
      end else begin
        want = pixel_words_due.pop_front();
        check_field("write_enable", want.we, m_tuser[0]);
        check_field("pixel_index", want.index, m_tdata[23:0]);
        check_field("pixel_value", want.value, m_tdata[39:24]);
        check_field("status", want.status, m_tdata[42:40]);
        check_field("run_last", want.last, m_tlast);
        check_field("image_done", want.done, m_tuser[1]);
      end
    end
  end

  initial begin
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: timeout, nothing moved for %0d cycles", $time, StallLimit);
    $display("status: fail");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = 1'b0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    s_tlast   = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // 4x2 frame: small enough to hit frame end and line starts
    set_geometry(13'd4, 13'd2);
    add_row(8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 24'd0, 16'h0000, ST_OK,       1'b1, 1'b0);
    add_row(8'h34, 1'b0, 1'b0, 1'b1, 1'b0, 24'd0, 16'h0000, ST_OK,       1'b1, 1'b0);
    add_row(8'h12, 1'b0, 1'b0, 1'b1, 1'b1, 24'd0, 16'h1234, ST_OK,       1'b1, 1'b0);
    add_row(8'h41, 1'b0, 1'b0, 1'b1, 1'b0, 24'd0, 16'h0000, ST_OK,       1'b1, 1'b0);
    add_row(8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, 24'd0, 16'h0000, ST_OK,       1'b1, 1'b0);
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0, 16'h0000, ST_OK,       1'b0, 1'b0);
    add_row(8'h80, 1'b0, 1'b0, 1'b1, 1'b0, 24'd0, 16'h0000, ST_OK,       1'b1, 1'b0);
    add_row(8'h21, 1'b0, 1'b0, 1'b1, 1'b0, 24'd0, 16'h0000, ST_OK,       1'b1, 1'b0);
    add_row(8'h80, 1'b0, 1'b0, 1'b1, 1'b0, 24'd0, 16'h0000, ST_OK,       1'b1, 1'b0);
    add_row(8'h20, 1'b0, 1'b0, 1'b1, 1'b0, 24'd0, 16'h0000, ST_OVERFLOW, 1'b1, 1'b0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0, 16'h0000, ST_OK,       1'b0, 1'b0);
    add_row(8'h81, 1'b1, 1'b0, 1'b1, 1'b0, 24'd0, 16'h0000, ST_BAD_LF,   1'b1, 1'b0);
    add_row(8'h60, 1'b1, 1'b0, 1'b1, 1'b0, 24'd0, 16'h0000, ST_UNKNOWN,  1'b1, 1'b0);
    add_row(8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, 24'd0, 16'h0000, ST_UNKNOWN,  1'b1, 1'b0);
    add_row(8'h24, 1'b1, 1'b0, 1'b1, 1'b0, 24'd0, 16'h0000, ST_OK,       1'b1, 1'b0);
    add_row(8'h80, 1'b0, 1'b0, 1'b1, 1'b0, 24'd0, 16'h0000, ST_PAST,     1'b1, 1'b0);
    add_row(8'h1F, 1'b1, 1'b0, 1'b1, 1'b0, 24'd0, 16'h0000, ST_OVERFLOW, 1'b1, 1'b0);
    add_row(8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 24'd0, 16'h0000, ST_OVERRUN,  1'b1, 1'b1);
    add_row(8'h47, 1'b1, 1'b0, 1'b1, 1'b0, 24'd0, 16'h0000, ST_OK,       1'b1, 1'b0);
    add_row(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 24'd0, 16'h0000, ST_OK,       1'b1, 1'b0);
    add_row(8'hAB, 1'b0, 1'b1, 1'b0, 1'b0, 24'd0, 16'h0000, ST_OK,       1'b0, 1'b0);
    add_row(8'h01, 1'b1, 1'b0, 1'b1, 1'b0, 24'd0, 16'h0000, ST_OK,       1'b1, 1'b0);
    add_row(8'h11, 1'b0, 1'b0, 1'b1, 1'b0, 24'd0, 16'h0000, ST_OK,       1'b1, 1'b0);
    add_row(8'h22, 1'b0, 1'b1, 1'b0, 1'b0, 24'd0, 16'h0000, ST_OK,       1'b0, 1'b0);
    add_row(8'h01, 1'b1, 1'b0, 1'b1, 1'b0, 24'd0, 16'h0000, ST_OK,       1'b1, 1'b0);
    add_row(8'h33, 1'b0, 1'b1, 1'b1, 1'b0, 24'd0, 16'h0000, ST_OVERRUN,  1'b1, 1'b1);
    run_script();
    quiesce();

    for (int g = 0; g < 6; g++) begin
      if (g < 5) set_geometry(pitch_set[g], height_set[g]);
      else set_geometry(13'($urandom_range(2, 24)), 13'($urandom_range(1, 6)));
      while (script.size() < 16) compose_image();
      run_script();
      quiesce();
    end

    $display("covered %0d bytes over %0d frame geometries", bytes_in, geometries);
    $display("checked %0d words: %0d pixel writes, %0d error words",
             words_out, writes_seen, err_words);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
